// File: hdl/fdbe_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and arithmetic helpers for the band-pass feedback echo.
// Used by the channel interfaces, the top level and its checker; depends on nothing.
package fdbe_pkg;

  // Storage sizing
  localparam int unsigned DELAY_DEPTH  = 65536;
  localparam int unsigned SAMPLE_WIDTH = 24;
  localparam int unsigned ADDR_W       = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

  // Fixed field widths
  localparam int unsigned IO_W       = 24;  // port samples, Q1.23
  localparam int unsigned COEF_W     = 24;  // biquad coefficients, Q2.22
  localparam int unsigned GAIN_W     = 17;  // gains, Q0.16 with 1.0 allowed
  localparam int unsigned DLEN_W     = 16;  // delay length register
  localparam int unsigned STATE_W    = 32;  // filter state words
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;

  // Shared multiplier and accumulator widths
  localparam int unsigned MUL_A_W = COEF_W + 1;
  localparam int unsigned MUL_B_W = (SAMPLE_WIDTH > IO_W) ? SAMPLE_WIDTH : IO_W;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = (MUL_B_W + 27 > 56) ? MUL_B_W + 28 : 57;

  // Fractional shifts
  localparam int unsigned COEF_FRAC = 22;
  localparam int unsigned GAIN_FRAC = 16;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(65536);

  // Saturation bounds in accumulator format
  localparam logic signed [ACC_W-1:0] SMP_HI = ACC_W'((longint'(1) << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SMP_LO = ~SMP_HI;
  localparam logic signed [ACC_W-1:0] ST_HI  = ACC_W'((longint'(1) << (STATE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] ST_LO  = ~ST_HI;
  localparam logic signed [ACC_W-1:0] IO_HI  = ACC_W'((longint'(1) << (IO_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] IO_LO  = ~IO_HI;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1       = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2       = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1       = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2       = CFG_IDX_W'(7);

  // Register reset values
  localparam logic [DLEN_W-1:0]        RST_DELAY_LENGTH = DLEN_W'(24000);
  localparam logic [GAIN_W-1:0]        RST_FEEDBACK     = GAIN_W'(0);
  localparam logic [GAIN_W-1:0]        RST_WET_MIX      = GAIN_W'(32768);
  localparam logic signed [COEF_W-1:0] RST_COEF_B0      = COEF_W'(4194304);

  // Sequencer steps: lag capture, memory read, eleven steps per channel, hand-off
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LAG,
    ST_READ,
    ST_T0,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_T4,
    ST_T5,
    ST_T6,
    ST_T7,
    ST_T8,
    ST_T9,
    ST_T10,
    ST_DONE
  } fdbe_state_e;

  // Round half up, then arithmetic shift right by n
  function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] v,
                                                        input int unsigned n);
    logic signed [ACC_W-1:0] half;
    logic signed [ACC_W-1:0] t;
    half = ACC_W'(1) << (n - 1);
    t    = v + half;
    return t >>> n;
  endfunction

  // Clamp into [lo, hi]
  function automatic logic signed [ACC_W-1:0] clamp(input logic signed [ACC_W-1:0] v,
                                                    input logic signed [ACC_W-1:0] hi,
                                                    input logic signed [ACC_W-1:0] lo);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > hi) r = hi;
    else if (v < lo) r = lo;
    return r;
  endfunction

endpackage

// File: hdl/fdbe_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the echo: sample input, mixed output, register writes.
// Widths come from fdbe_pkg.

interface fdbe_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fdbe_pkg::IO_W-1:0]     left_in;
  logic signed [fdbe_pkg::IO_W-1:0]     right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface fdbe_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fdbe_pkg::IO_W-1:0]     left_out;
  logic signed [fdbe_pkg::IO_W-1:0]     right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface fdbe_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [fdbe_pkg::CFG_IDX_W-1:0]       index;
  logic [fdbe_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/feedback_delay_bandpass_echo.sv
`timescale 1ns / 1ps
// Each frame runs lag capture, memory read, the channel steps, then hand-off to the output.
// Input is taken only when idle; one shared multiplier runs 8 products
// per channel in 11 steps, and a stalled result holds the hand-off step until it is taken.
// Reset (async, active low): registers take their defaults, filter state and write pointer
// clear; delay lines read as zero until written, tracked by the write pointer and a wrap flag.
// Depends on fdbe_pkg and the interfaces in fdbe_if.sv.
module feedback_delay_bandpass_echo (
  input  logic        clk_i,
  input  logic        rst_ni,
  fdbe_in_if.sink     in_i,
  fdbe_out_if.source  out_o,
  fdbe_cfg_if.sink    cfg_i
);

  localparam int unsigned SW  = fdbe_pkg::SAMPLE_WIDTH;
  localparam int unsigned AW  = fdbe_pkg::ADDR_W;
  localparam int unsigned AW1 = AW + 1;
  localparam logic [AW1-1:0] DEPTH_EXT = AW1'(fdbe_pkg::DELAY_DEPTH);
  localparam logic [AW-1:0]  LAST_ADDR = AW'(fdbe_pkg::DELAY_DEPTH - 1);

  // ------------------------------------------------------------------
  // Configuration registers; the write port never stalls
  // ------------------------------------------------------------------
  logic [fdbe_pkg::DLEN_W-1:0]        delay_q;
  logic [fdbe_pkg::GAIN_W-1:0]        fb_q, wet_q;
  logic signed [fdbe_pkg::COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= fdbe_pkg::RST_DELAY_LENGTH;
      fb_q    <= fdbe_pkg::RST_FEEDBACK;
      wet_q   <= fdbe_pkg::RST_WET_MIX;
      b0_q    <= fdbe_pkg::RST_COEF_B0;
      b1_q    <= '0;
      b2_q    <= '0;
      a1_q    <= '0;
      a2_q    <= '0;
    end else if (cfg_i.valid) begin
      // Drop writes to unknown indexes
      unique case (cfg_i.index)
        fdbe_pkg::REG_DELAY_LENGTH:  delay_q <= cfg_i.data[fdbe_pkg::DLEN_W-1:0];
        fdbe_pkg::REG_FEEDBACK_GAIN: fb_q    <= cfg_i.data[fdbe_pkg::GAIN_W-1:0];
        fdbe_pkg::REG_WET_MIX:       wet_q   <= cfg_i.data[fdbe_pkg::GAIN_W-1:0];
        fdbe_pkg::REG_COEF_B0:       b0_q    <= cfg_i.data[fdbe_pkg::COEF_W-1:0];
        fdbe_pkg::REG_COEF_B1:       b1_q    <= cfg_i.data[fdbe_pkg::COEF_W-1:0];
        fdbe_pkg::REG_COEF_B2:       b2_q    <= cfg_i.data[fdbe_pkg::COEF_W-1:0];
        fdbe_pkg::REG_COEF_A1:       a1_q    <= cfg_i.data[fdbe_pkg::COEF_W-1:0];
        fdbe_pkg::REG_COEF_A2:       a2_q    <= cfg_i.data[fdbe_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Wet gain saturates at 1.0; dry gets the rest
  logic [fdbe_pkg::GAIN_W-1:0] wet_c, dry_c;
  assign wet_c = (wet_q > fdbe_pkg::UNITY_GAIN) ? fdbe_pkg::UNITY_GAIN : wet_q;
  assign dry_c = fdbe_pkg::UNITY_GAIN - wet_c;

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  fdbe_pkg::fdbe_state_e state_q, state_d;
  logic                           ch_q;      // 0 = left, 1 = right
  logic                           in_acc, out_acc, out_load;
  logic                           out_valid_q;

  assign in_i.ready  = (state_q == fdbe_pkg::ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_acc     = out_valid_q && out_o.ready;
  assign out_o.valid = out_valid_q;

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      fdbe_pkg::ST_IDLE: if (in_acc) state_d = fdbe_pkg::ST_LAG;
      fdbe_pkg::ST_LAG:  state_d = fdbe_pkg::ST_READ;
      fdbe_pkg::ST_READ: state_d = fdbe_pkg::ST_T0;
      fdbe_pkg::ST_T0:   state_d = fdbe_pkg::ST_T1;
      fdbe_pkg::ST_T1:   state_d = fdbe_pkg::ST_T2;
      fdbe_pkg::ST_T2:   state_d = fdbe_pkg::ST_T3;
      fdbe_pkg::ST_T3:   state_d = fdbe_pkg::ST_T4;
      fdbe_pkg::ST_T4:   state_d = fdbe_pkg::ST_T5;
      fdbe_pkg::ST_T5:   state_d = fdbe_pkg::ST_T6;
      fdbe_pkg::ST_T6:   state_d = fdbe_pkg::ST_T7;
      fdbe_pkg::ST_T7:   state_d = fdbe_pkg::ST_T8;
      fdbe_pkg::ST_T8:   state_d = fdbe_pkg::ST_T9;
      fdbe_pkg::ST_T9:   state_d = fdbe_pkg::ST_T10;
      fdbe_pkg::ST_T10:  state_d = ch_q ? fdbe_pkg::ST_DONE : fdbe_pkg::ST_T0;
      fdbe_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = fdbe_pkg::ST_IDLE;
        end
      end
      default: state_d = fdbe_pkg::ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Write pointer and fill tracking
  // ------------------------------------------------------------------
  logic [AW-1:0] wr_q;
  logic          wrapped_q;   // every slot written at least once

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdbe_pkg::ST_IDLE;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
      wr_q        <= '0;
      wrapped_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        ch_q <= 1'b0;
      end else if (state_q == fdbe_pkg::ST_T10) begin
        ch_q <= ~ch_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        // Advance one slot per frame
        if (wr_q == LAST_ADDR) begin
          wr_q      <= '0;
          wrapped_q <= 1'b1;
        end else begin
          wr_q <= wr_q + 1'b1;
        end
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Lag = delay_length mod depth; the depth is a power of two, so keep the low address bits
  // ------------------------------------------------------------------
  logic [AW-1:0]  rem_q;

  // Read address: write pointer minus lag, wrapped
  logic [AW1-1:0] rd_diff, rd_wrap;
  logic [AW-1:0]  rd_addr;
  logic           rd_written;

  assign rd_diff    = {1'b0, wr_q} - {1'b0, rem_q};
  assign rd_wrap    = rd_diff[AW] ? rd_diff + DEPTH_EXT : rd_diff;
  assign rd_addr    = rd_wrap[AW-1:0];
  assign rd_written = wrapped_q || (rd_addr < wr_q);

  // ------------------------------------------------------------------
  // Delay memories, one per channel, registered read
  // ------------------------------------------------------------------
  logic signed [SW-1:0] mem_l [fdbe_pkg::DELAY_DEPTH];
  logic signed [SW-1:0] mem_r [fdbe_pkg::DELAY_DEPTH];
  logic signed [SW-1:0] rdata_l_q, rdata_r_q, wdata;
  logic                 we_l, we_r;

  assign we_l = (state_q == fdbe_pkg::ST_T7) && !ch_q;
  assign we_r = (state_q == fdbe_pkg::ST_T7) && ch_q;

  always_ff @(posedge clk_i) begin
    if (we_l) mem_l[wr_q] <= wdata;
    if (state_q == fdbe_pkg::ST_READ) rdata_l_q <= mem_l[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (we_r) mem_r[wr_q] <= wdata;
    if (state_q == fdbe_pkg::ST_READ) rdata_r_q <= mem_r[rd_addr];
  end

  // ------------------------------------------------------------------
  // Shared multiplier and accumulator
  // ------------------------------------------------------------------
  logic signed [fdbe_pkg::IO_W-1:0]    x_q [2];
  logic signed [SW-1:0]                y_q;
  logic                                dvalid_q;
  logic signed [fdbe_pkg::STATE_W-1:0] s1_q [2];
  logic signed [fdbe_pkg::STATE_W-1:0] s2_q [2];
  logic signed [fdbe_pkg::PROD_W-1:0]  prod_q;
  logic signed [fdbe_pkg::ACC_W-1:0]   acc_q;
  logic signed [fdbe_pkg::IO_W-1:0]    res_q [2];
  logic signed [fdbe_pkg::IO_W-1:0]    out_l_q, out_r_q;

  logic signed [SW-1:0]                d_sel;
  logic signed [fdbe_pkg::IO_W-1:0]    x_sel;
  logic signed [fdbe_pkg::MUL_A_W-1:0] mul_a;
  logic signed [fdbe_pkg::MUL_B_W-1:0] mul_b;

  assign d_sel = !dvalid_q ? '0 : (ch_q ? rdata_r_q : rdata_l_q);
  assign x_sel = x_q[ch_q];

  // Operand choice per step; the product is registered in prod_q
  always_comb begin
    mul_a = fdbe_pkg::MUL_A_W'(b1_q);
    mul_b = fdbe_pkg::MUL_B_W'(d_sel);
    unique case (state_q)
      fdbe_pkg::ST_T0: mul_a = fdbe_pkg::MUL_A_W'(b0_q);
      fdbe_pkg::ST_T3: begin
        mul_a = fdbe_pkg::MUL_A_W'(a1_q);
        mul_b = fdbe_pkg::MUL_B_W'(y_q);
      end
      fdbe_pkg::ST_T4: mul_a = fdbe_pkg::MUL_A_W'(b2_q);
      fdbe_pkg::ST_T5: begin
        mul_a = fdbe_pkg::MUL_A_W'(a2_q);
        mul_b = fdbe_pkg::MUL_B_W'(y_q);
      end
      fdbe_pkg::ST_T6: begin
        mul_a = $signed(fdbe_pkg::MUL_A_W'(fb_q));
        mul_b = fdbe_pkg::MUL_B_W'(y_q);
      end
      fdbe_pkg::ST_T7: begin
        mul_a = $signed(fdbe_pkg::MUL_A_W'(dry_c));
        mul_b = fdbe_pkg::MUL_B_W'(x_sel);
      end
      fdbe_pkg::ST_T8: begin
        mul_a = $signed(fdbe_pkg::MUL_A_W'(wet_c));
        mul_b = fdbe_pkg::MUL_B_W'(y_q);
      end
      default: ;
    endcase
  end

  // Rescale and saturate paths
  logic signed [fdbe_pkg::ACC_W-1:0] prod_ext, acc_r22, acc_r16;
  logic signed [fdbe_pkg::ACC_W-1:0] y_new, s1_new, s2_new, st_new, o_new;

  assign prod_ext = fdbe_pkg::ACC_W'(prod_q);
  assign acc_r22  = fdbe_pkg::rnd_shift(acc_q, fdbe_pkg::COEF_FRAC);
  assign acc_r16  = fdbe_pkg::rnd_shift(acc_q, fdbe_pkg::GAIN_FRAC);
  assign y_new    = fdbe_pkg::clamp(acc_r22, fdbe_pkg::SMP_HI, fdbe_pkg::SMP_LO);
  assign s1_new   = fdbe_pkg::clamp(acc_r22 + fdbe_pkg::ACC_W'(s2_q[ch_q]),
                                    fdbe_pkg::ST_HI, fdbe_pkg::ST_LO);
  assign s2_new   = fdbe_pkg::clamp(acc_r22, fdbe_pkg::ST_HI, fdbe_pkg::ST_LO);
  assign st_new   = fdbe_pkg::clamp(fdbe_pkg::ACC_W'(x_sel)
                                    + fdbe_pkg::rnd_shift(prod_ext, fdbe_pkg::GAIN_FRAC),
                                    fdbe_pkg::SMP_HI, fdbe_pkg::SMP_LO);
  assign o_new    = fdbe_pkg::clamp(acc_r16, fdbe_pkg::IO_HI, fdbe_pkg::IO_LO);
  assign wdata    = st_new[SW-1:0];

  // Filter state: transposed direct form II, s1 and s2 per channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q[0] <= '0;
      s1_q[1] <= '0;
      s2_q[0] <= '0;
      s2_q[1] <= '0;
    end else begin
      if (state_q == fdbe_pkg::ST_T5) s1_q[ch_q] <= s1_new[fdbe_pkg::STATE_W-1:0];
      if (state_q == fdbe_pkg::ST_T7) s2_q[ch_q] <= s2_new[fdbe_pkg::STATE_W-1:0];
    end
  end

  // Datapath payload
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_acc) begin
      x_q[0] <= in_i.left_in;
      x_q[1] <= in_i.right_in;
    end
    unique case (state_q)
      fdbe_pkg::ST_LAG:  rem_q <= AW'(delay_q);
      fdbe_pkg::ST_READ: dvalid_q <= rd_written;
      // y = b0*d + s1
      fdbe_pkg::ST_T1:   acc_q <= prod_ext + (fdbe_pkg::ACC_W'(s1_q[ch_q]) <<< fdbe_pkg::COEF_FRAC);
      fdbe_pkg::ST_T2: begin
        y_q   <= y_new[SW-1:0];
        acc_q <= prod_ext;               // b1*d
      end
      fdbe_pkg::ST_T4:   acc_q <= acc_q - prod_ext;   // minus a1*y
      fdbe_pkg::ST_T5:   acc_q <= prod_ext;           // b2*d
      fdbe_pkg::ST_T6:   acc_q <= acc_q - prod_ext;   // minus a2*y
      fdbe_pkg::ST_T8:   acc_q <= prod_ext;           // dry*x
      fdbe_pkg::ST_T9:   acc_q <= acc_q + prod_ext;   // plus wet*y
      fdbe_pkg::ST_T10:  res_q[ch_q] <= o_new[fdbe_pkg::IO_W-1:0];
      default: ;
    endcase
    if (out_load) begin
      out_l_q <= res_q[0];
      out_r_q <= res_q[1];
    end
  end

  assign out_o.left_out  = out_l_q;
  assign out_o.right_out = out_r_q;

endmodule

// File: hdl/fdbe_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the band-pass feedback echo, bound to the top level.
// Depends on fdbe_pkg for widths.
module fdbe_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [fdbe_pkg::IO_W-1:0]  left_out_i,
  input logic signed [fdbe_pkg::IO_W-1:0]  right_out_i,
  input logic                              cfg_ready_i
);

  // One frame at a time: busy right after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while a frame is in progress");

  // A result never appears the cycle after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !$rose(out_valid_i))
    else $error("result appeared too early after an input item");

  // A new result always comes with the input side open again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("input side not ready when a result was issued");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(left_out_i) && $stable(right_out_i)))
    else $error("stalled result changed or dropped");

  // Register writes are never stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port not ready");

endmodule

bind feedback_delay_bandpass_echo fdbe_checker u_fdbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .left_out_i  (out_o.left_out),
  .right_out_i (out_o.right_out),
  .cfg_ready_i (cfg_i.ready)
);

// File: tb/tb_feedback_delay_bandpass_echo.sv
`timescale 1ns / 1ps
// Self-checking testbench for the band-pass feedback echo: a directed table, then random phases.
// Depends on fdbe_pkg, the channel interfaces in fdbe_if.sv and feedback_delay_bandpass_echo.
module tb_feedback_delay_bandpass_echo;
  import fdbe_pkg::*;

  // Run limits. The cycle limit leaves a wide margin for ~1950 frames with random gaps
  // and stalls on both sides.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned IDLE_PCT      = 13;
  localparam int unsigned RANDOM_FRAMES = 1900;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned MAX_PRINTED   = 40;

  // Indexes outside the register file; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(8);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(15);

  localparam longint GAIN_ONE = 65536;

  // Stable band-pass in Q2.22: b = 0.1 * (1, 0, -1), a1 = -1.6, a2 = 0.8
  localparam longint BP_B0 = 419430;
  localparam longint BP_B2 = -419430;
  localparam longint BP_A1 = -6710886;
  localparam longint BP_A2 = 3355443;

  typedef logic signed [IO_W-1:0] sample_t;

  localparam sample_t S_MAX = IO_W'((longint'(1) << (IO_W - 1)) - 1);
  localparam sample_t S_MIN = IO_W'(longint'(1) << (IO_W - 1));

  typedef struct packed {
    sample_t left;
    sample_t right;
  } mix_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_FRAME, ROW_KNOWN} row_kind_e;
  typedef enum logic [1:0] {SIG_FULL, SIG_QUIET, SIG_BURST, SIG_EDGE} signal_style_e;

  typedef struct {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    sample_t                 left;
    sample_t                 right;
    mix_t                    known;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;   // suppress all idling on both sides while set

  fdbe_in_if  in_ch ();
  fdbe_out_if out_ch ();
  fdbe_cfg_if cfg_ch ();

  feedback_delay_bandpass_echo dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Echo predictor: its own register copy, delay lines, biquad state, write pointer
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_WIDTH-1:0] echo_mem [2][DELAY_DEPTH];
  logic signed [STATE_W-1:0]      bq_state [2][2];   // per channel: s1, s2
  logic [ADDR_W-1:0]              wr_ptr;
  logic [DLEN_W-1:0]              dly_len;
  logic [GAIN_W-1:0]              fb_gain;
  logic [GAIN_W-1:0]              wet_gain;
  logic signed [COEF_W-1:0]       coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  mix_t mix_q [$];   // expected mixes, oldest first
  mix_t want_mix;

  int     n_mismatch;
  int     n_frames;
  int     n_checked;
  int     n_writes;
  int     n_settings;
  longint cycle_count;

  function automatic longint round_half_up(longint v, int unsigned n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint saturate(longint v, int unsigned w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic void reset_model();
    for (int ch = 0; ch < 2; ch++) begin
      for (int a = 0; a < DELAY_DEPTH; a++) echo_mem[ch][a] = '0;
      bq_state[ch][0] = '0;
      bq_state[ch][1] = '0;
    end
    wr_ptr   = '0;
    dly_len  = RST_DELAY_LENGTH;
    fb_gain  = RST_FEEDBACK;
    wet_gain = RST_WET_MIX;
    coef_b0  = RST_COEF_B0;
    coef_b1  = '0;
    coef_b2  = '0;
    coef_a1  = '0;
    coef_a2  = '0;
  endfunction

  // Keep only the bits each register holds; drop writes to unknown indexes
  function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_DELAY_LENGTH:  dly_len  = data[DLEN_W-1:0];
      REG_FEEDBACK_GAIN: fb_gain  = data[GAIN_W-1:0];
      REG_WET_MIX:       wet_gain = data[GAIN_W-1:0];
      REG_COEF_B0:       coef_b0  = data[COEF_W-1:0];
      REG_COEF_B1:       coef_b1  = data[COEF_W-1:0];
      REG_COEF_B2:       coef_b2  = data[COEF_W-1:0];
      REG_COEF_A1:       coef_a1  = data[COEF_W-1:0];
      REG_COEF_A2:       coef_a2  = data[COEF_W-1:0];
      default: ;
    endcase
  endfunction

  // Filter the delayed sample, write the feedback sum, return the dry/wet mix
  function automatic sample_t run_channel(int ch, longint x, logic [ADDR_W-1:0] rd);
    longint d;
    longint y;
    longint w;
    d = echo_mem[ch][rd];
    // wet mix above one acts as fully wet
    w = (longint'(wet_gain) > GAIN_ONE) ? GAIN_ONE : longint'(wet_gain);
    y = saturate(round_half_up(longint'(coef_b0) * d
                               + (longint'(bq_state[ch][0]) <<< COEF_FRAC), COEF_FRAC),
                 SAMPLE_WIDTH);
    // s1 takes the old s2, so update it first
    bq_state[ch][0] = STATE_W'(saturate(round_half_up(longint'(coef_b1) * d
                                                      - longint'(coef_a1) * y, COEF_FRAC)
                                        + longint'(bq_state[ch][1]), STATE_W));
    bq_state[ch][1] = STATE_W'(saturate(round_half_up(longint'(coef_b2) * d
                                                      - longint'(coef_a2) * y, COEF_FRAC),
                                        STATE_W));
    // feedback above one is used as written
    echo_mem[ch][wr_ptr] = SAMPLE_WIDTH'(saturate(x + round_half_up(y * longint'(fb_gain),
                                                                    GAIN_FRAC), SAMPLE_WIDTH));
    return IO_W'(saturate(round_half_up(x * (GAIN_ONE - w) + y * w, GAIN_FRAC), IO_W));
  endfunction

  function automatic mix_t predict_echo(sample_t l, sample_t r);
    logic [ADDR_W-1:0] rd;
    mix_t m;
    // a lag of zero (mod depth) reads the slot about to be overwritten
    rd = wr_ptr - ADDR_W'(dly_len % DELAY_DEPTH);
    m.left  = run_channel(0, longint'(l), rd);
    m.right = run_channel(1, longint'(r), rd);
    wr_ptr  = wr_ptr + 1'b1;
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers: change inputs on the falling edge, sample on the rising edge
  // ---------------------------------------------------------------------------
  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_mismatch++;
    if (n_mismatch <= MAX_PRINTED)
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Offer one frame; leave valid high so a back-to-back frame needs no toggle.
  // On acceptance step the predictor, and queue the typed-in mix instead where given.
  task automatic send_frame(sample_t l, sample_t r, bit known, mix_t known_mix);
    mix_t m;
    @(negedge clk);
    while (take_break()) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.left_in  = l;
    in_ch.right_in = r;
    do @(posedge clk); while (!in_ch.ready);
    m = predict_echo(l, r);
    mix_q.push_back(known ? known_mix : m);
    n_frames++;
  endtask

  // Drop the frame valid and wait until every expected mix has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (mix_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    while (take_break()) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    write_reg(idx, data);
    n_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Value in the low w bits; a quarter of the time fill the unused upper bits with noise
  function automatic logic [CFG_DATA_W-1:0] with_junk(longint v, int unsigned w);
    logic [CFG_DATA_W-1:0] data;
    logic [CFG_DATA_W-1:0] mask;
    mask = (CFG_DATA_W'(1) << w) - 1'b1;
    data = CFG_DATA_W'(v) & mask;
    if ($urandom_range(0, 3) == 0) data = data | (CFG_DATA_W'($urandom()) & ~mask);
    return data;
  endfunction

  function automatic longint draw_gain();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return GAIN_ONE;
      2, 3:    return $urandom_range(32'(GAIN_ONE + 1), (1 << GAIN_W) - 1);
      default: return $urandom_range(0, 32'(GAIN_ONE));
    endcase
  endfunction

  function automatic longint jitter();
    return longint'($urandom_range(0, 2000)) - 1000;
  endfunction

  // Write a fresh setting of every register, plus one write to a spare index
  task automatic pick_setting();
    longint lag;
    bit     tame;
    case ($urandom_range(0, 9))
      0:       lag = 0;
      1:       lag = (1 << DLEN_W) - 1;
      2:       lag = $urandom_range(41, 2000);
      3:       lag = $urandom_range(0, (1 << DLEN_W) - 1);
      default: lag = $urandom_range(1, 40);
    endcase
    cfg_write(REG_DELAY_LENGTH, with_junk(lag, DLEN_W));
    cfg_write(REG_FEEDBACK_GAIN, with_junk(draw_gain(), GAIN_W));
    cfg_write(REG_WET_MIX, with_junk(draw_gain(), GAIN_W));
    // mostly a stable band-pass, sometimes arbitrary coefficients
    tame = ($urandom_range(0, 9) < 7);
    cfg_write(REG_COEF_B0, tame ? CFG_DATA_W'(BP_B0 + jitter()) : CFG_DATA_W'($urandom()));
    cfg_write(REG_COEF_B1, tame ? CFG_DATA_W'(jitter()) : CFG_DATA_W'($urandom()));
    cfg_write(REG_COEF_B2, tame ? CFG_DATA_W'(BP_B2 + jitter()) : CFG_DATA_W'($urandom()));
    cfg_write(REG_COEF_A1, tame ? CFG_DATA_W'(BP_A1 + jitter()) : CFG_DATA_W'($urandom()));
    cfg_write(REG_COEF_A2, tame ? CFG_DATA_W'(BP_A2 + jitter()) : CFG_DATA_W'($urandom()));
    cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), CFG_DATA_W'($urandom()));
    n_settings++;
  endtask

  function automatic sample_t draw_sample(signal_style_e style);
    case (style)
      SIG_FULL:  return IO_W'($urandom());
      SIG_QUIET: return IO_W'(longint'($urandom_range(0, 131071)) - 65536);
      SIG_BURST: return ($urandom_range(0, 7) == 0) ? IO_W'($urandom()) : sample_t'(0);
      default: begin
        case ($urandom_range(0, 5))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       return sample_t'(0);
          3:       return sample_t'(1);
          4:       return sample_t'(-1);
          default: return IO_W'($urandom());
        endcase
      end
    endcase
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: data, left: '0, right: '0, known: '0};
    return r;
  endfunction

  function automatic row_t frame_row(sample_t l, sample_t rt);
    row_t r;
    r = '{kind: ROW_FRAME, idx: '0, data: '0, left: l, right: rt, known: '0};
    return r;
  endfunction

  function automatic row_t known_row(sample_t l, sample_t rt, sample_t el, sample_t er);
    row_t r;
    r = '{kind: ROW_KNOWN, idx: '0, data: '0, left: l, right: rt, known: {el, er}};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, compare each mix with the oldest expectation
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = !take_break();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (mix_q.size() == 0) begin
        report_mismatch("mix with nothing pending, left_out", out_ch.left_out, 0);
      end else begin
        want_mix = mix_q.pop_front();
        n_checked++;
        if (out_ch.left_out !== want_mix.left)
          report_mismatch("left_out", out_ch.left_out, want_mix.left);
        if (out_ch.right_out !== want_mix.right)
          report_mismatch("right_out", out_ch.right_out, want_mix.right);
      end
    end
  end

  // Hard stop: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles, %0d mixes pending", $time, cycle_count,
               mix_q.size());
      $display("feedback_delay_bandpass_echo: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    row_t          dir_rows [$];
    signal_style_e style;
    int            phase;
    int            stop_at;

    rst_n          = 1'b0;
    calm           = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.left_in  = '0;
    in_ch.right_in = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    reset_model();

    // Defaults: delay lines empty and b0 = 1, so the wet path is zero and the mix is x/2,
    // rounding half up.
    dir_rows.push_back(known_row(0, 0, 0, 0));
    dir_rows.push_back(known_row(S_MAX, S_MIN, 4194304, -4194304));
    dir_rows.push_back(known_row(1, -1, 1, 0));
    // Fully dry: the input passes unchanged
    dir_rows.push_back(cfg_row(REG_WET_MIX, 0));
    dir_rows.push_back(known_row(S_MAX, S_MIN, S_MAX, S_MIN));
    dir_rows.push_back(known_row(-5, 777, -5, 777));
    // Wet mix above one, all data bits set: fully wet, still silent
    dir_rows.push_back(cfg_row(REG_WET_MIX, '1));
    dir_rows.push_back(known_row(123456, -654321, 0, 0));
    // One-frame echo at unity feedback: an impulse recirculates
    dir_rows.push_back(cfg_row(REG_DELAY_LENGTH, 1));
    dir_rows.push_back(cfg_row(REG_FEEDBACK_GAIN, CFG_DATA_W'(GAIN_ONE)));
    dir_rows.push_back(cfg_row(REG_WET_MIX, 32768));
    dir_rows.push_back(frame_row(S_MAX, S_MIN));
    dir_rows.push_back(frame_row(0, 0));
    dir_rows.push_back(frame_row(0, 0));
    dir_rows.push_back(frame_row(0, 0));
    // Zero delay reads the slot about to be overwritten
    dir_rows.push_back(cfg_row(REG_DELAY_LENGTH, 0));
    dir_rows.push_back(frame_row(4000000, -4000000));
    dir_rows.push_back(frame_row(0, 0));
    // Spare indexes must not disturb anything
    dir_rows.push_back(cfg_row(REG_SPARE_LO, 24'hABCDEF));
    dir_rows.push_back(cfg_row(REG_SPARE_HI, 24'h123456));
    // Coefficient extremes with feedback above one: drive every saturation
    dir_rows.push_back(cfg_row(REG_COEF_B0, S_MIN));
    dir_rows.push_back(cfg_row(REG_COEF_B1, S_MAX));
    dir_rows.push_back(cfg_row(REG_COEF_B2, S_MIN));
    dir_rows.push_back(cfg_row(REG_COEF_A1, S_MAX));
    dir_rows.push_back(cfg_row(REG_COEF_A2, S_MIN));
    dir_rows.push_back(cfg_row(REG_FEEDBACK_GAIN, CFG_DATA_W'((1 << GAIN_W) - 1)));
    dir_rows.push_back(cfg_row(REG_DELAY_LENGTH, 2));
    dir_rows.push_back(frame_row(S_MAX, S_MIN));
    dir_rows.push_back(frame_row(S_MIN, S_MAX));
    dir_rows.push_back(frame_row(S_MAX, S_MAX));
    dir_rows.push_back(frame_row(0, 0));
    dir_rows.push_back(frame_row(-1, 1));
    dir_rows.push_back(frame_row(0, 0));
    // Longest delay
    dir_rows.push_back(cfg_row(REG_DELAY_LENGTH, CFG_DATA_W'((1 << DLEN_W) - 1)));
    dir_rows.push_back(frame_row(1000, -1000));

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Walk the table; hold every register write until the block has gone quiet
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          drain_results();
          cfg_write(dir_rows[i].idx, dir_rows[i].data);
        end
        ROW_KNOWN: send_frame(dir_rows[i].left, dir_rows[i].right, 1'b1, dir_rows[i].known);
        default:   send_frame(dir_rows[i].left, dir_rows[i].right, 1'b0, '0);
      endcase
    end

    // Random phases: new setting, then a run of frames in one signal style.
    // The third phase runs with no idling on either side.
    phase   = 0;
    stop_at = n_frames + RANDOM_FRAMES;
    while (n_frames < stop_at) begin
      drain_results();
      pick_setting();
      calm  = (phase == 2);
      style = signal_style_e'($urandom_range(0, 3));
      repeat ($urandom_range(120, 200))
        send_frame(draw_sample(style), draw_sample(style), 1'b0, '0);
      phase++;
    end
    calm = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d mixes from %0d frames over %0d random settings and the directed table",
             n_checked, n_frames, n_settings);
    $display("%0d register writes, %0d mismatches, %0d cycles", n_writes, n_mismatch,
             cycle_count);
    if (n_mismatch == 0 && mix_q.size() == 0) begin
      $display("feedback_delay_bandpass_echo: match");
    end else begin
      $display("feedback_delay_bandpass_echo: mismatch");
    end
    $finish;
  end

endmodule
